FILE: design/mcorl_pkg.sv
package mcorl_pkg;

    localparam int SLOTS       = 192;
    localparam int VOICE_SLOTS = 64;
    localparam int MAX_OUT     = 64;
    localparam int IDX_W       = 8;

    localparam logic [3:0] KIND_BEND     = 4'hE;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;
    localparam logic [3:0] KIND_POLY     = 4'hA;
    localparam logic [3:0] KIND_CC       = 4'hB;
    localparam logic [7:0] CC_TIMBRE     = 8'd74;
    localparam logic [15:0] NEVER_SENT   = 16'hFFFF;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_PERIOD = 3'd1;
    localparam logic [2:0] REG_TPT    = 3'd2;
    localparam logic [2:0] REG_CAP    = 3'd3;
    localparam logic [2:0] REG_OCAP   = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [31:0] period;
        logic [24:0] tpt;
        logic [39:0] cap;
        logic [6:0]  ocap;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic addr_slot;
        logic push_upd;
        logic push_set;
        logic push_clr;
        logic emit;
        logic tok_dec;
        logic vis_clr;
        logic idx_clr;
        logic idx_inc;
        logic scan_step;
        logic refill_mul;
        logic refill_add;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic mode;
        logic has_slot;
        logic exempt;
        logic same_val;
        logic pend_idx;
        logic pend_cur;
        logic elig;
        logic idx_last;
        logic tok_ok;
        logic vis_full;
        logic can_emit;
        logic can_flush;
        logic hold_v;
    } sts_t;

    // {valid, slot}
    function automatic logic [IDX_W:0] slot_of(logic [7:0] st, logic [7:0] d1);
        logic [3:0] kind;
        logic [3:0] ch;
        kind = st[7:4];
        ch   = st[3:0];
        if (kind == KIND_BEND)
            slot_of = {1'b1, 2'b00, ch, 2'd0};
        else if (kind == KIND_PRESSURE)
            slot_of = {1'b1, 2'b00, ch, 2'd1};
        else if (kind == KIND_POLY)
            slot_of = {1'b1, 2'b00, ch, 2'd3};
        else if (kind == KIND_CC && ch == 4'd0)
            slot_of = {1'b1, 8'(VOICE_SLOTS) + {1'b0, d1[6:0]}};
        else if (kind == KIND_CC && d1 == CC_TIMBRE)
            slot_of = {1'b1, 2'b00, ch, 2'd2};
        else
            slot_of = '0;
    endfunction

    function automatic logic [15:0] value_of(logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
        if (st[7:4] == KIND_BEND)
            value_of = 16'({8'd0, d1} | ({8'd0, d2} << 7));
        else if (st[7:4] == KIND_PRESSURE)
            value_of = {8'd0, d1};
        else
            value_of = {8'd0, d2};
    endfunction

endpackage

FILE: design/midi_change_only_rate_limiter_core.sv
// Change-only MIDI output limiter.
// Input channel (in_valid/in_stall): one item is a push of a 3-byte message
// or a drain-only request, with the current tick time. Output channel
// (out_valid/out_stall): zero or more messages per item, last_flag on the
// final one. Configuration over the APB port, 64-bit registers at 8*i.
// Items are handled one at a time; in_stall is high while an item is in work.
// A push that passes straight through or is dropped only visits the decode,
// check and finish states. A rate-mode drain walks all 192 slots, with an
// extra check state for each pending slot. A budget-mode drain first refills
// the tokens, then visits slots in turn, with a read and an emit step per emit.
// Results leave through one output register; one further result is held
// back so the final one can be flagged, so the block only waits when both
// are full and the receiver stalls. Reset clears all slot flags, loads one
// token and the register defaults; no clearing pass is needed.
module midi_change_only_rate_limiter_core
    import mcorl_pkg::*;
#(
    parameter int TOKEN_FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] time_ticks,
    input  logic [7:0]  msg_status,
    input  logic [7:0]  msg_data1,
    input  logic [7:0]  msg_data2,
    input  logic        exempt,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_status,
    output logic [7:0]  out_data1,
    output logic [7:0]  out_data2,
    output logic        last_flag
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    mcorl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcorl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcorl_dp #(
        .TOKEN_FRAC_BITS (TOKEN_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (operation),
        .time_ticks (time_ticks),
        .msg_status (msg_status),
        .msg_data1  (msg_data1),
        .msg_data2  (msg_data2),
        .exempt     (exempt),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_status (out_status),
        .out_data1  (out_data1),
        .out_data2  (out_data2),
        .last_flag  (last_flag)
    );

endmodule

FILE: design/mcorl_regs.sv
module mcorl_regs
    import mcorl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic [2:0] sel;

    assign sel    = paddr[5:3];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= 1'b0;
            cfg_reg.period <= 32'd10000;
            cfg_reg.tpt    <= 25'd16777;
            cfg_reg.cap    <= 40'd1677721600;
            cfg_reg.ocap   <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (sel)
                REG_MODE:   cfg_reg.mode   <= pwdata[0];
                REG_PERIOD: cfg_reg.period <= pwdata[31:0];
                REG_TPT:    cfg_reg.tpt    <= pwdata[24:0];
                REG_CAP:    cfg_reg.cap    <= pwdata[39:0];
                REG_OCAP:   cfg_reg.ocap   <= pwdata[6:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_MODE:   prdata = {63'd0, cfg_reg.mode};
            REG_PERIOD: prdata = {32'd0, cfg_reg.period};
            REG_TPT:    prdata = {39'd0, cfg_reg.tpt};
            REG_CAP:    prdata = {24'd0, cfg_reg.cap};
            REG_OCAP:   prdata = {57'd0, cfg_reg.ocap};
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: design/mcorl_dp.sv
module mcorl_dp
    import mcorl_pkg::*;
#(
    parameter int TOKEN_FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        operation,
    input  logic [31:0] time_ticks,
    input  logic [7:0]  msg_status,
    input  logic [7:0]  msg_data1,
    input  logic [7:0]  msg_data2,
    input  logic        exempt,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_status,
    output logic [7:0]  out_data1,
    output logic [7:0]  out_data2,
    output logic        last_flag
);

    localparam logic [39:0] TOK_ONE = 40'(64'd1 << TOKEN_FRAC_BITS);

    // latched item
    logic        op_reg, ex_reg;
    logic [31:0] now_reg;
    logic [7:0]  st_reg, d1_reg, d2_reg;

    logic [SLOTS-1:0] pend_reg, emitted_reg;
    logic [23:0]      msg_mem [SLOTS];
    logic [47:0]      tv_mem  [SLOTS];   // {last value, last emit time}
    logic [23:0]      msg_rd_reg;
    logic [47:0]      tv_rd_reg;

    logic [IDX_W-1:0] idx_reg, cur_reg;
    logic [IDX_W-1:0] vis_reg;
    logic [39:0]      tok_reg;
    logic [56:0]      prod_reg;
    logic             started_reg;
    logic [31:0]      refill_t_reg;
    logic [6:0]       kept_reg;
    logic             hold_v_reg;
    logic [23:0]      hold_reg;
    logic             out_v_reg, out_last_reg;
    logic [23:0]      out_reg;

    logic [IDX_W:0]   slot_info;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] rd_addr;
    logic [15:0]      in_val, last_val, emit_val;
    logic [23:0]      in_msg;
    logic [6:0]       cap_eff;
    logic             keep;
    logic [57:0]      tok_sum;
    logic [31:0]      delta;
    logic             do_push;
    logic [23:0]      push_msg;
    logic             tv_we;
    logic [IDX_W-1:0] tv_addr;
    logic [47:0]      tv_wdata;

    assign slot_info = slot_of(st_reg, d1_reg);
    assign slot      = slot_info[IDX_W-1:0];
    assign in_val    = value_of(st_reg, d1_reg, d2_reg);
    assign in_msg    = {st_reg, d1_reg, d2_reg};
    assign emit_val  = value_of(msg_rd_reg[23:16], msg_rd_reg[15:8], msg_rd_reg[7:0]);
    assign rd_addr   = cmd.addr_slot ? slot : idx_reg;
    assign last_val  = emitted_reg[slot] ? tv_rd_reg[47:32] : NEVER_SENT;
    assign cap_eff   = (cfg.ocap > 7'(MAX_OUT)) ? 7'(MAX_OUT) : cfg.ocap;
    assign keep      = kept_reg < cap_eff;
    assign tok_sum   = {18'd0, tok_reg} + {1'b0, prod_reg};
    assign delta     = started_reg ? (now_reg - refill_t_reg) : 32'd0;

    assign do_push  = (cmd.emit || cmd.push_upd) && keep;
    assign push_msg = cmd.emit ? msg_rd_reg : in_msg;

    assign tv_we    = cmd.emit || (cmd.push_upd && slot_info[IDX_W]);
    assign tv_addr  = cmd.emit ? idx_reg : slot;
    assign tv_wdata = cmd.emit ? {emit_val, now_reg} : {in_val, now_reg};

    always_comb
    begin
        sts.op        = op_reg;
        sts.mode      = cfg.mode;
        sts.has_slot  = slot_info[IDX_W];
        sts.exempt    = ex_reg;
        sts.same_val  = in_val == last_val;
        sts.pend_idx  = pend_reg[idx_reg];
        sts.pend_cur  = pend_reg[cur_reg];
        sts.elig      = !emitted_reg[idx_reg] || ((now_reg - tv_rd_reg[31:0]) >= cfg.period);
        sts.idx_last  = idx_reg == IDX_W'(SLOTS - 1);
        sts.tok_ok    = tok_reg >= TOK_ONE;
        sts.vis_full  = vis_reg == IDX_W'(SLOTS);
        sts.can_flush = !out_v_reg || !out_stall;
        sts.can_emit  = !keep || !hold_v_reg || !out_v_reg || !out_stall;
        sts.hold_v    = hold_v_reg;
    end

    always_ff @(posedge clk)
    begin
        msg_rd_reg <= msg_mem[rd_addr];
        tv_rd_reg  <= tv_mem[rd_addr];
        if (cmd.push_set)
            msg_mem[slot] <= in_msg;
        if (tv_we)
            tv_mem[tv_addr] <= tv_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            ex_reg  <= exempt;
            now_reg <= time_ticks;
            st_reg  <= msg_status;
            d1_reg  <= msg_data1;
            d2_reg  <= msg_data2;
        end
        if (cmd.refill_mul)
            prod_reg <= {25'd0, delta} * {32'd0, cfg.tpt};
        if (cmd.refill_mul)
            refill_t_reg <= now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            emitted_reg  <= '0;
            idx_reg      <= '0;
            cur_reg      <= '0;
            vis_reg      <= '0;
            tok_reg      <= TOK_ONE;
            started_reg  <= 1'b0;
            kept_reg     <= '0;
            hold_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            out_last_reg <= 1'b0;
            hold_reg     <= '0;
            out_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
                kept_reg <= '0;
            if (cmd.push_clr)
                pend_reg[slot] <= 1'b0;
            if (cmd.push_set)
                pend_reg[slot] <= 1'b1;
            if (cmd.push_upd && slot_info[IDX_W])
            begin
                pend_reg[slot]    <= 1'b0;
                emitted_reg[slot] <= 1'b1;
            end
            if (cmd.emit)
            begin
                pend_reg[idx_reg]    <= 1'b0;
                emitted_reg[idx_reg] <= 1'b1;
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            else if (cmd.scan_step)
                idx_reg <= cur_reg;
            if (cmd.scan_step)
            begin
                cur_reg <= (cur_reg == IDX_W'(SLOTS - 1)) ? '0 : cur_reg + 1'b1;
                vis_reg <= vis_reg + 1'b1;
            end
            if (cmd.vis_clr || cmd.refill_add)
                vis_reg <= '0;
            if (cmd.refill_mul)
                started_reg <= 1'b1;
            if (cmd.refill_add)
                tok_reg <= (tok_sum > {18'd0, cfg.cap}) ? cfg.cap : tok_sum[39:0];
            else if (cmd.tok_dec)
                tok_reg <= tok_reg - TOK_ONE;

            // output stage, with one result held back to learn which is last
            if (!out_stall)
                out_v_reg <= 1'b0;
            if (do_push)
            begin
                kept_reg <= kept_reg + 1'b1;
                hold_reg <= push_msg;
                hold_v_reg <= 1'b1;
                if (hold_v_reg)
                begin
                    out_reg      <= hold_reg;
                    out_last_reg <= 1'b0;
                    out_v_reg    <= 1'b1;
                end
            end
            else if (cmd.flush)
            begin
                out_reg      <= hold_reg;
                out_last_reg <= 1'b1;
                out_v_reg    <= 1'b1;
                hold_v_reg   <= 1'b0;
            end
        end
    end

    assign out_valid  = out_v_reg;
    assign out_status = out_reg[23:16];
    assign out_data1  = out_reg[15:8];
    assign out_data2  = out_reg[7:0];
    assign last_flag  = out_last_reg;

endmodule

FILE: design/mcorl_ctrl.sv
module mcorl_ctrl
    import mcorl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_PUSH_CHK, S_DRAIN, S_RATE_SCAN, S_RATE_CHK,
        S_REFILL_MUL, S_REFILL_ADD, S_BUD_SCAN, S_BUD_RD, S_BUD_EMIT, S_FINISH
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            S_DECODE:
            begin
                cmd.addr_slot = 1'b1;
                state_next    = sts.op ? S_DRAIN : S_PUSH_CHK;
            end
            S_PUSH_CHK:
                priority if (!sts.has_slot || sts.exempt)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.push_upd = 1'b1;
                        state_next   = S_FINISH;
                    end
                end
                else if (sts.same_val)
                begin
                    cmd.push_clr = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.push_set = 1'b1;
                    state_next   = S_DRAIN;
                end
            S_DRAIN:
                if (sts.mode)
                    state_next = S_REFILL_MUL;
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_RATE_SCAN;
                end
            S_RATE_SCAN:
                priority if (sts.pend_idx)
                    state_next = S_RATE_CHK;
                else if (sts.idx_last)
                    state_next = S_FINISH;
                else
                    cmd.idx_inc = 1'b1;
            S_RATE_CHK:
                if (!sts.elig || sts.can_emit)
                begin
                    cmd.emit = sts.elig;
                    if (sts.idx_last)
                        state_next = S_FINISH;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RATE_SCAN;
                    end
                end
            S_REFILL_MUL:
            begin
                cmd.refill_mul = 1'b1;
                state_next     = S_REFILL_ADD;
            end
            S_REFILL_ADD:
            begin
                cmd.refill_add = 1'b1;
                state_next     = S_BUD_SCAN;
            end
            S_BUD_SCAN:
                if (!sts.tok_ok || sts.vis_full)
                    state_next = S_FINISH;
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.pend_cur)
                        state_next = S_BUD_RD;
                end
            S_BUD_RD:
                state_next = S_BUD_EMIT;
            S_BUD_EMIT:
                if (sts.can_emit)
                begin
                    cmd.emit    = 1'b1;
                    cmd.tok_dec = 1'b1;
                    cmd.vis_clr = 1'b1;
                    state_next  = S_BUD_SCAN;
                end
            S_FINISH:
                if (!sts.hold_v)
                    state_next = S_IDLE;
                else if (sts.can_flush)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
